// ===== src/lfu_pkg.sv =====
// Shared types and constants for the LFU cache policy block.
// Used by every module under src; depends on nothing else.
package lfu_pkg;

	localparam int unsigned ENTRIES_DEF = 16;
	localparam int unsigned KEY_W       = 32;
	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned COUNT_W     = 16;
	localparam int unsigned STAMP_W     = 48;
	localparam int unsigned CAP_W       = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
	localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef struct packed {
		logic                      action;
		logic signed [KEY_W-1:0]   key;
		logic signed [VALUE_W-1:0] value;
	} req_beat_t;

	typedef struct packed {
		logic                      hit;
		logic signed [VALUE_W-1:0] read_value;
		logic                      evicted;
	} rsp_beat_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic found;
		logic victim_found;
		logic free_found;
	} scan_flags_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

endpackage

// ===== src/lfu_cache_policy_core.sv =====
// LFU cache with least-recent tie-break: sequencer, valid bits and counters.
// An item is scanned one entry per cycle through the shared compare unit,
// then passes the drain and commit states, and commit waits while the held
// response is stalled; the next request is taken only back in idle.
// Reset clears the valid bits, occupancy and touch clock and sets capacity to 16.
module lfu_cache_policy_core import lfu_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_beat_t        req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_beat_t        rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
	localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);
	localparam logic [CNT_W-1:0] LAST_C    = CNT_W'(ENTRIES - 1);

	state_t             state_q, state_d;
	req_beat_t          req_q;
	rsp_beat_t          rsp_q, rsp_d;
	logic               rsp_valid_q;
	logic [CAP_W-1:0]   cap_q;
	logic [CNT_W-1:0]   occ_q, occ_d;
	logic [STAMP_W-1:0] clock_q;
	logic [ENTRIES-1:0] entry_valid_q;
	logic [CNT_W-1:0]   scan_cnt_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;

	logic               accept;
	logic               rd_en;
	logic               scan_last;
	logic               commit;
	logic               wr_en;
	logic               mem_we;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_data;
	entry_t             rd_data;
	scan_flags_t        flags;
	logic [IDX_W-1:0]   found_idx;
	logic [VALUE_W-1:0] found_value;
	logic [COUNT_W-1:0] found_count;
	logic [IDX_W-1:0]   victim_idx;
	logic [IDX_W-1:0]   free_idx;
	logic [CMP_W-1:0]   cap_ext;
	logic [CMP_W-1:0]   cap_eff;
	logic [CMP_W-1:0]   occ_ext;
	logic [COUNT_W-1:0] count_inc;

	assign accept    = req_valid && !req_stall;
	assign scan_last = (scan_cnt_q == LAST_C);
	assign mem_we    = commit && wr_en;

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		rd_en     = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (accept) begin
				scan_cnt_q <= '0;
			end else if (rd_en) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (rd_en) begin
			rd_idx_s1 <= scan_cnt_q[IDX_W-1:0];
		end
	end

	lfu_entry_mem #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_idx  (scan_cnt_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	lfu_scan_unit #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (accept),
		.key         (req_q.key),
		.elem_vld    (rd_vld_s1),
		.elem_valid  (entry_valid_q[rd_idx_s1]),
		.elem_idx    (rd_idx_s1),
		.elem        (rd_data),
		.flags       (flags),
		.found_idx   (found_idx),
		.found_value (found_value),
		.found_count (found_count),
		.victim_idx  (victim_idx),
		.free_idx    (free_idx)
	);

	always_comb begin
		cap_ext   = CMP_W'(cap_q);
		cap_eff   = (cap_ext > ENTRIES_C) ? ENTRIES_C : cap_ext;
		occ_ext   = CMP_W'(occ_q);
		count_inc = (found_count == COUNT_MAX) ? found_count : found_count + COUNT_ONE;

		wr_en         = 1'b0;
		wr_idx        = found_idx;
		wr_data.key   = req_q.key;
		wr_data.value = found_value;
		wr_data.count = count_inc;
		wr_data.stamp = clock_q;
		occ_d         = occ_q;

		rsp_d.hit        = flags.found;
		rsp_d.read_value = '0;
		rsp_d.evicted    = 1'b0;

		if (req_q.action == ACT_GET) begin
			if (flags.found) begin
				wr_en            = 1'b1;
				rsp_d.read_value = found_value;
			end else begin
				rsp_d.read_value = '1;
			end
		end else if (cap_eff != '0) begin
			wr_data.value = req_q.value;
			if (flags.found) begin
				wr_en = 1'b1;
			end else begin
				wr_data.count = COUNT_ONE;
				if ((occ_ext >= cap_eff) && flags.victim_found) begin
					wr_en         = 1'b1;
					wr_idx        = victim_idx;
					rsp_d.evicted = 1'b1;
				end else if (flags.free_found) begin
					wr_en  = 1'b1;
					wr_idx = free_idx;
					occ_d  = occ_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q         <= CAP_RESET;
			occ_q         <= '0;
			clock_q       <= '0;
			entry_valid_q <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
				occ_q       <= occ_d;
				if (wr_en) begin
					entry_valid_q[wr_idx] <= 1'b1;
					clock_q               <= clock_q + STAMP_W'(1);
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== src/lfu_entry_mem.sv =====
// Entry store: key, value, use count and last-touch stamp per slot.
// One write port and one registered read port; uses lfu_pkg.
module lfu_entry_mem import lfu_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_idx,
	input  entry_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output entry_t           rd_data
);

	entry_t mem_q [ENTRIES];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/lfu_scan_unit.sv =====
// Shared compare unit: takes one entry per cycle and keeps the key match,
// the eviction victim and the lowest free slot. Uses lfu_pkg.
module lfu_scan_unit import lfu_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	parameter int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear,
	input  logic [KEY_W-1:0]   key,
	input  logic               elem_vld,
	input  logic               elem_valid,
	input  logic [IDX_W-1:0]   elem_idx,
	input  entry_t             elem,
	output scan_flags_t        flags,
	output logic [IDX_W-1:0]   found_idx,
	output logic [VALUE_W-1:0] found_value,
	output logic [COUNT_W-1:0] found_count,
	output logic [IDX_W-1:0]   victim_idx,
	output logic [IDX_W-1:0]   free_idx
);

	scan_flags_t        flags_q;
	logic [IDX_W-1:0]   found_idx_q;
	logic [VALUE_W-1:0] found_value_q;
	logic [COUNT_W-1:0] found_count_q;
	logic [IDX_W-1:0]   victim_idx_q;
	logic [COUNT_W-1:0] victim_count_q;
	logic [STAMP_W-1:0] victim_stamp_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               take_match;
	logic               take_victim;
	logic               take_free;

	always_comb begin
		take_match  = elem_vld && elem_valid && !flags_q.found && (elem.key == key);
		take_victim = elem_vld && elem_valid &&
			(!flags_q.victim_found || (elem.count < victim_count_q) ||
			 ((elem.count == victim_count_q) && (elem.stamp < victim_stamp_q)));
		take_free   = elem_vld && !elem_valid && !flags_q.free_found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clear) begin
			flags_q <= '0;
		end else begin
			if (take_match) begin
				flags_q.found <= 1'b1;
			end
			if (take_victim) begin
				flags_q.victim_found <= 1'b1;
			end
			if (take_free) begin
				flags_q.free_found <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_match) begin
			found_idx_q   <= elem_idx;
			found_value_q <= elem.value;
			found_count_q <= elem.count;
		end
		if (take_victim) begin
			victim_idx_q   <= elem_idx;
			victim_count_q <= elem.count;
			victim_stamp_q <= elem.stamp;
		end
		if (take_free) begin
			free_idx_q <= elem_idx;
		end
	end

	assign flags       = flags_q;
	assign found_idx   = found_idx_q;
	assign found_value = found_value_q;
	assign found_count = found_count_q;
	assign victim_idx  = victim_idx_q;
	assign free_idx    = free_idx_q;

endmodule

// ===== src/lfu_chk.sv =====
// Port-level checker for lfu_cache_policy_core, bound to every instance.
// Sees only the top-level ports; uses lfu_pkg.
module lfu_chk import lfu_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input rsp_beat_t        rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled response beat changed or was dropped.");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("Request taken while the previous one is still being scanned.");

	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.evicted |-> !rsp.hit)
		else $error("Eviction reported on a hit.");

	a_evict_put: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.evicted |-> rsp.read_value == '0)
		else $error("Eviction reported on a beat that is not a put.");

endmodule

bind lfu_cache_policy_core lfu_chk u_lfu_chk (.*);

// ===== verif/lfu_cache_mirror_pkg.sv =====
// Response predictor and checker for the LFU cache policy block.
// Keeps its own copy of the cache contents, use counts and touch stamps.
// Depends on lfu_pkg for the beat types, widths and action codes.
package lfu_cache_mirror_pkg;
	import lfu_pkg::*;

	class lfu_cache_mirror;
		bit                 slot_used[ENTRIES_DEF];
		bit [KEY_W-1:0]     slot_key[ENTRIES_DEF];
		bit [VALUE_W-1:0]   slot_value[ENTRIES_DEF];
		bit [COUNT_W-1:0]   slot_uses[ENTRIES_DEF];
		bit [STAMP_W-1:0]   slot_stamp[ENTRIES_DEF];
		bit [STAMP_W-1:0]   touch_clock;
		int unsigned        held;
		bit [CAP_W-1:0]     capacity;
		rsp_beat_t          pending_rsp[$];
		int unsigned        mismatches;

		function new();
			foreach (slot_used[i]) begin
				slot_used[i] = 1'b0;
			end
			touch_clock = '0;
			held        = 0;
			capacity    = CAP_RESET;
			mismatches  = 0;
		endfunction

		function void set_capacity(bit [CAP_W-1:0] cap);
			capacity = cap;
		endfunction

		function int unsigned outstanding();
			return pending_rsp.size();
		endfunction

		function void report(string what);
			mismatches++;
			$display("MISMATCH: %s", what);
		endfunction

		function void touch(int slot);
			slot_stamp[slot] = touch_clock;
			touch_clock      = touch_clock + 1'b1;
		endfunction

		function void bump_use(int slot);
			if (slot_uses[slot] != COUNT_MAX) begin
				slot_uses[slot] = slot_uses[slot] + 1'b1;
			end
			touch(slot);
		endfunction

		// Works out the response to an accepted request beat and updates the cache copy.
		function void note_request(req_beat_t r);
			int          found;
			int          slot;
			int unsigned cap;
			rsp_beat_t   e;
			found = -1;
			slot  = -1;
			cap   = (capacity > ENTRIES_DEF) ? ENTRIES_DEF : capacity;
			for (int i = 0; i < ENTRIES_DEF; i++) begin
				if (found < 0 && slot_used[i] && slot_key[i] == r.key) begin
					found = i;
				end
			end
			e.hit        = (found >= 0);
			e.read_value = '0;
			e.evicted    = 1'b0;
			if (r.action == ACT_GET) begin
				if (found >= 0) begin
					bump_use(found);
					e.read_value = slot_value[found];
				end else begin
					e.read_value = '1;
				end
			end else if (cap != 0) begin
				if (found >= 0) begin
					slot_value[found] = r.value;
					bump_use(found);
				end else begin
					if (held >= cap) begin
						for (int i = 0; i < ENTRIES_DEF; i++) begin
							if (slot_used[i] && (slot < 0 || slot_uses[i] < slot_uses[slot] ||
									(slot_uses[i] == slot_uses[slot] &&
									 slot_stamp[i] < slot_stamp[slot]))) begin
								slot = i;
							end
						end
						if (slot >= 0) begin
							slot_used[slot] = 1'b0;
							if (held > 0) begin
								held--;
							end
							e.evicted = 1'b1;
						end
					end
					if (slot < 0) begin
						for (int i = ENTRIES_DEF - 1; i >= 0; i--) begin
							if (!slot_used[i]) begin
								slot = i;
							end
						end
					end
					if (slot >= 0) begin
						slot_used[slot]  = 1'b1;
						slot_key[slot]   = r.key;
						slot_value[slot] = r.value;
						slot_uses[slot]  = COUNT_ONE;
						touch(slot);
						held++;
					end
				end
			end
			pending_rsp.push_back(e);
		endfunction

		function void check_response(rsp_beat_t got);
			rsp_beat_t e;
			if (pending_rsp.size() == 0) begin
				report($sformatf("response beat with nothing outstanding: hit %b value %h",
					got.hit, got.read_value));
			end else begin
				e = pending_rsp.pop_front();
				if (got.hit !== e.hit) begin
					report($sformatf("hit is %b, expected %b", got.hit, e.hit));
				end
				if (got.read_value !== e.read_value) begin
					report($sformatf("read_value is %h, expected %h",
						got.read_value, e.read_value));
				end
				if (got.evicted !== e.evicted) begin
					report($sformatf("evicted is %b, expected %b", got.evicted, e.evicted));
				end
			end
		endfunction
	endclass

endpackage

// ===== verif/tb_lfu_cache_policy_core.sv =====
// Self-checking testbench for lfu_cache_policy_core: directed and random gets and puts
// under several capacities, random idling on both sides, checked against a cache copy.
// Depends on lfu_pkg and lfu_cache_mirror_pkg.
module tb_lfu_cache_policy_core;
	timeunit 1ns;
	timeprecision 1ps;
	import lfu_pkg::*;
	import lfu_cache_mirror_pkg::*;

	localparam int PHASE_ITEMS = 175;
	localparam int IDLE_LIMIT  = 2000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_beat_t        req = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_beat_t        rsp;
	logic             cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	lfu_cache_mirror  mirror;
	bit               quiet_phase = 1'b0;
	int               idle_cycles;
	logic [KEY_W-1:0] key_pool[$];

	lfu_cache_policy_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic req_beat_t beat(logic act, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
		req_beat_t r;
		r.action = act;
		r.key    = k;
		r.value  = v;
		return r;
	endfunction

	function automatic req_beat_t random_beat();
		req_beat_t r;
		int        top;
		top      = key_pool.size() - 1;
		r.action = $urandom_range(0, 1) ? ACT_PUT : ACT_GET;
		if ($urandom_range(0, 6) == 0) begin
			r.key = $urandom;
		end else if ($urandom_range(0, 2) == 0) begin
			r.key = key_pool[$urandom_range(0, top)];
		end else begin
			r.key = key_pool[$urandom_range(0, top / 3)];
		end
		r.value = $urandom;
		return r;
	endfunction

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic send_req(input req_beat_t item);
		int gap;
		gap = quiet_phase ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		mirror.note_request(item);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (mirror.outstanding() != 0);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		drain();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.set_capacity(cap);
	endtask

	task automatic build_pool(input logic [CAP_W-1:0] cap);
		int n;
		n = ((cap > ENTRIES_DEF) ? ENTRIES_DEF : cap) + $urandom_range(1, 6);
		key_pool.delete();
		if ($urandom_range(0, 1)) begin
			key_pool.push_back(32'h8000_0000);
			key_pool.push_back(32'h7FFF_FFFF);
			key_pool.push_back(32'hFFFF_FFFF);
			key_pool.push_back(32'h0000_0000);
		end
		while (key_pool.size() < n) begin
			key_pool.push_back($urandom);
		end
	endtask

	initial begin
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				mirror.check_response(rsp);
				hold = quiet_phase ? 0 : $urandom_range(0, 5);
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				if (rsp_valid) begin
					hold--;
				end
			end else begin
				rsp_stall <= !quiet_phase && !rsp_valid && ($urandom_range(0, 3) == 0);
			end
		end
	end

	initial begin
		@(posedge arst_n);
		wait (idle_cycles >= IDLE_LIMIT);
		$display("tb_lfu_cache_policy_core NOT OK");
		$finish;
	end

	initial begin
		logic [CAP_W-1:0] caps[10];
		caps   = '{5'd31, 5'd16, 5'd4, 5'd1, 5'd0, 5'd17, 5'd8, 5'd2, 5'd16, 5'd12};
		mirror = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty cache, extreme keys and values, updates and hits at the reset capacity.
		send_req(beat(ACT_GET, 32'h0000_0000, 32'h1234_5678));
		send_req(beat(ACT_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
		send_req(beat(ACT_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
		send_req(beat(ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF));
		send_req(beat(ACT_PUT, 32'h7FFF_FFFF, 32'h0000_0000));
		send_req(beat(ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000));
		send_req(beat(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000));
		send_req(beat(ACT_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_req(beat(ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000));

		// Full cache: two entries share the lowest count, so the older one goes.
		write_capacity(5'd3);
		send_req(beat(ACT_PUT, 32'h0000_0005, 32'h0000_0055));
		send_req(beat(ACT_GET, 32'h8000_0000, 32'h0000_0000));

		// Capacity below occupancy: the victim's slot is reused.
		write_capacity(5'd1);
		send_req(beat(ACT_PUT, 32'h0000_0006, 32'h0000_0066));
		send_req(beat(ACT_GET, 32'h0000_0005, 32'h0000_0000));

		// Capacity zero ignores puts but still serves gets.
		write_capacity(5'd0);
		send_req(beat(ACT_PUT, 32'h0000_0007, 32'h0000_0077));
		send_req(beat(ACT_PUT, 32'h0000_0006, 32'hDEAD_BEEF));
		send_req(beat(ACT_GET, 32'h0000_0006, 32'h0000_0000));
		send_req(beat(ACT_GET, 32'h0000_0007, 32'h0000_0000));

		foreach (caps[p]) begin
			write_capacity(caps[p]);
			build_pool(caps[p]);
			quiet_phase = (p % 4 == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) == 0) begin
					drain();
				end
				send_req(random_beat());
			end
		end
		quiet_phase = 1'b0;

		drain();
		repeat (ENTRIES_DEF + 3) @(posedge clk);
		if (mirror.outstanding() != 0) begin
			mirror.report($sformatf("%0d expected responses never arrived",
				mirror.outstanding()));
		end
		if (mirror.mismatches == 0) begin
			$display("tb_lfu_cache_policy_core OK");
		end else begin
			$display("tb_lfu_cache_policy_core NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/lfu_pkg.sv
src/lfu_entry_mem.sv
src/lfu_scan_unit.sv
src/lfu_cache_policy_core.sv
src/lfu_chk.sv
verif/lfu_cache_mirror_pkg.sv
verif/tb_lfu_cache_policy_core.sv
